@@ rtl/ac_pkg.sv @@
// ----------------------------------------------------------------------------
// ac_pkg: shared types and constants for the Aho-Corasick match counter
// Opcodes, sequencer states, lookup contexts and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ac_pkg;

  localparam int NODES_DEF    = 512;
  localparam int ALPHABET_DEF = 256;
  localparam int OP_W         = 3;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = 32;

  localparam logic [CNT_W-1:0] TOTAL_MAX = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_PAT_BYTE  = 3'd1,
    OP_PAT_END   = 3'd2,
    OP_BUILD     = 3'd3,
    OP_TEXT_BYTE = 3'd4,
    OP_LINE_END  = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_E_RD,
    S_E_META,
    S_E_CHK,
    S_NODE_RD,
    S_NODE_Q,
    S_NEXT_SYM,
    S_Q_RD,
    S_Q_WAIT,
    S_U_FAIL
  } state_t;

  typedef enum logic [2:0] {
    CTX_PAT,
    CTX_WALK,
    CTX_FINAL,
    CTX_ROOT,
    CTX_CHILD,
    CTX_ENDP
  } ctx_t;

endpackage

`default_nettype wire

@@ rtl/ac_if.sv @@
// ----------------------------------------------------------------------------
// ac_if: valid/ready channels of the Aho-Corasick match counter
// Command word channel and result word channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ac_in_if;
  logic                       valid;
  logic                       ready;
  logic [ac_pkg::OP_W-1:0]    opcode;
  logic [ac_pkg::SYM_W-1:0]   data_byte;

  modport source (output valid, opcode, data_byte, input ready);
  modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface ac_out_if;
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [ac_pkg::CNT_W-1:0]   total_count;
  logic                       status;

  modport source (output valid, matched, total_count, status, input ready);
  modport sink   (input valid, matched, total_count, status, output ready);
endinterface

`default_nettype wire

@@ rtl/aho_corasick_match_counter_core.sv @@
// ----------------------------------------------------------------------------
// aho_corasick_match_counter_core: byte-alphabet Aho-Corasick match counter
// Builds a trie from pattern words, links it breadth-first, scans text words.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one command word (opcode, data_byte); out_ch returns one
// result word (matched, total_count, status) per command. Both are valid/ready.
// One command is in flight at a time; a single lookup sequencer shares the
// goto RAM, the node RAM and the BFS queue RAM.
// Sequence per word: clear, end line and unused opcodes finish on acceptance;
// a pattern byte reads the goto entry, then the target node, then checks the
// edge; end pattern marks the node terminal (the root at once); a text byte
// follows failure links to a hit or the root; build links the root's children, then each queued node.
// Reset (and clear) empties the trie at once: edges are checked against the
// parent and symbol recorded in the child node, so no RAM clearing pass.
// A result waiting on a stalled receiver holds in the output register; the
// next command is taken in the cycle the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aho_corasick_match_counter_core #(
  parameter int NODES    = ac_pkg::NODES_DEF,
  parameter int ALPHABET = ac_pkg::ALPHABET_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ac_in_if.sink     in_ch,
  ac_out_if.source  out_ch
);

  localparam int NW      = $clog2(NODES);
  localparam int NCW     = $clog2(NODES + 1);
  localparam int GAW     = $clog2(NODES * ALPHABET);
  localparam int SW      = ac_pkg::SYM_W;
  localparam int NDW     = 2 * NW + SW + 1;
  localparam int FAIL_LO = 1;
  localparam int SYM_LO  = 1 + NW;
  localparam int PAR_LO  = 1 + NW + SW;

  ac_pkg::state_t  state_r, state_nxt;
  ac_pkg::ctx_t    ctx_r, ctx_nxt;
  ac_pkg::opcode_t op_r, op_nxt;

  logic [SW-1:0]           sym_r, sym_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic [NW-1:0]           c_r, c_nxt;
  logic [NW-1:0]           u_r, u_nxt;
  logic [NW-1:0]           ufail_r, ufail_nxt;
  logic [NW-1:0]           child_r, child_nxt;
  logic [NW-1:0]           child_par_r, child_par_nxt;
  logic                    child_term_r, child_term_nxt;
  logic [NCW-1:0]          steps_r, steps_nxt;
  logic [NCW-1:0]          head_r, head_nxt;
  logic [NCW-1:0]          tail_r, tail_nxt;
  logic [NCW-1:0]          node_cnt_r, node_cnt_nxt;
  logic [NW-1:0]           cursor_r, cursor_nxt;
  logic [ac_pkg::CNT_W-1:0] total_r, total_nxt;
  logic                    root_term_r, root_term_nxt;
  logic [GAW-1:0]          goto_addr_r, goto_addr_nxt;

  logic                    out_valid_r;
  logic                    out_matched_r;
  logic [ac_pkg::CNT_W-1:0] out_total_r;
  logic                    out_status_r;

  logic [SW-1:0] sym_map [256];

  for (genvar g = 0; g < 256; g++) begin : g_sym
    assign sym_map[g] = SW'(g % ALPHABET);
  end

  // memories
  logic           goto_we;
  logic [GAW-1:0] goto_addr;
  logic [NW-1:0]  goto_wdata, goto_q;
  logic           node_we;
  logic [NW-1:0]  node_waddr, node_raddr;
  logic [NDW-1:0] node_wdata, node_q;
  logic           q_we;
  logic [NW-1:0]  q_waddr, q_wdata, q_q;

  ac_ram #(.W(NW), .D(NODES * ALPHABET)) u_goto (
    .clk, .we(goto_we), .waddr(goto_addr_r), .wdata(goto_wdata),
    .raddr(goto_addr), .rdata(goto_q)
  );

  ac_ram #(.W(NDW), .D(NODES)) u_node (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_q)
  );

  ac_ram #(.W(NW), .D(NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[NW-1:0]), .rdata(q_q)
  );

  // edge check and shared decision terms
  logic          acc, hit, term_e, sym_last, full, walk_fin, done;
  logic          done_matched, done_status;
  logic [NW-1:0] e;
  logic [NW-1:0] q_par, q_fail;
  logic [SW-1:0] q_sym;

  assign q_par  = node_q[PAR_LO +: NW];
  assign q_sym  = node_q[SYM_LO +: SW];
  assign q_fail = node_q[FAIL_LO +: NW];

  assign acc       = in_ch.valid && in_ch.ready;
  assign goto_addr = GAW'(n_r) * GAW'(ALPHABET) + GAW'(sym_r);
  assign hit       = (c_r != '0) && (NCW'(c_r) < node_cnt_r) &&
                     (q_par == n_r) && (q_sym == sym_r);
  assign e         = hit ? c_r : '0;
  assign term_e    = hit ? node_q[0] : root_term_r;
  assign sym_last  = (sym_r == SW'(ALPHABET - 1));
  assign full      = (node_cnt_r >= NCW'(NODES));
  assign walk_fin  = (state_r == ac_pkg::S_E_CHK) &&
                     ((ctx_r == ac_pkg::CTX_WALK && hit) || ctx_r == ac_pkg::CTX_FINAL);
  assign done      = (state_r == ac_pkg::S_IDLE) ? (acc && state_nxt == ac_pkg::S_IDLE)
                                                 : (state_nxt == ac_pkg::S_IDLE);

  assign in_ch.ready = (state_r == ac_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ac_pkg::S_IDLE: begin
        if (acc) begin
          case (ac_pkg::opcode_t'(in_ch.opcode))
            ac_pkg::OP_PAT_BYTE:  state_nxt = ac_pkg::S_E_RD;
            ac_pkg::OP_PAT_END:   state_nxt = (cursor_r == '0) ? ac_pkg::S_IDLE
                                                               : ac_pkg::S_NODE_RD;
            ac_pkg::OP_BUILD:     state_nxt = ac_pkg::S_E_RD;
            ac_pkg::OP_TEXT_BYTE: state_nxt = ac_pkg::S_WALK;
            default:              state_nxt = ac_pkg::S_IDLE;
          endcase
        end
      end
      ac_pkg::S_WALK:   state_nxt = ac_pkg::S_E_RD;
      ac_pkg::S_E_RD:   state_nxt = ac_pkg::S_E_META;
      ac_pkg::S_E_META: state_nxt = ac_pkg::S_E_CHK;
      ac_pkg::S_E_CHK: begin
        case (ctx_r)
          ac_pkg::CTX_WALK: begin
            if (hit) begin
              state_nxt = (op_r == ac_pkg::OP_TEXT_BYTE) ? ac_pkg::S_IDLE
                                                         : ac_pkg::S_NEXT_SYM;
            end else if (steps_r >= NCW'(NODES)) begin
              state_nxt = ac_pkg::S_E_RD;
            end else begin
              state_nxt = ac_pkg::S_NODE_RD;
            end
          end
          ac_pkg::CTX_FINAL: state_nxt = (op_r == ac_pkg::OP_TEXT_BYTE) ? ac_pkg::S_IDLE
                                                                       : ac_pkg::S_NEXT_SYM;
          ac_pkg::CTX_ROOT:  state_nxt = sym_last ? ac_pkg::S_Q_RD : ac_pkg::S_E_RD;
          ac_pkg::CTX_CHILD: state_nxt = hit ? ac_pkg::S_WALK : ac_pkg::S_NEXT_SYM;
          default:           state_nxt = ac_pkg::S_IDLE;
        endcase
      end
      ac_pkg::S_NODE_RD:  state_nxt = ac_pkg::S_NODE_Q;
      ac_pkg::S_NODE_Q:   state_nxt = (ctx_r == ac_pkg::CTX_WALK) ? ac_pkg::S_WALK
                                                                  : ac_pkg::S_IDLE;
      ac_pkg::S_NEXT_SYM: state_nxt = sym_last ? ac_pkg::S_Q_RD : ac_pkg::S_E_RD;
      ac_pkg::S_Q_RD:     state_nxt = (head_r == tail_r) ? ac_pkg::S_IDLE : ac_pkg::S_Q_WAIT;
      ac_pkg::S_Q_WAIT:   state_nxt = ac_pkg::S_U_FAIL;
      ac_pkg::S_U_FAIL:   state_nxt = ac_pkg::S_E_RD;
      default:            state_nxt = ac_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ctx_nxt        = ctx_r;
    op_nxt         = op_r;
    sym_nxt        = sym_r;
    n_nxt          = n_r;
    c_nxt          = c_r;
    u_nxt          = u_r;
    ufail_nxt      = ufail_r;
    child_nxt      = child_r;
    child_par_nxt  = child_par_r;
    child_term_nxt = child_term_r;
    steps_nxt      = steps_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    node_cnt_nxt   = node_cnt_r;
    cursor_nxt     = cursor_r;
    total_nxt      = total_r;
    root_term_nxt  = root_term_r;
    goto_addr_nxt  = goto_addr_r;
    goto_we        = 1'b0;
    goto_wdata     = node_cnt_r[NW-1:0];
    node_we        = 1'b0;
    node_waddr     = n_r;
    node_wdata     = node_q;
    q_we           = 1'b0;
    q_waddr        = tail_r[NW-1:0];
    q_wdata        = c_r;
    done_matched   = 1'b0;
    done_status    = 1'b0;

    case (state_r)
      ac_pkg::S_E_META: node_raddr = goto_q;
      ac_pkg::S_Q_WAIT: node_raddr = q_q;
      default:          node_raddr = n_r;
    endcase

    case (state_r)
      ac_pkg::S_IDLE: begin
        if (acc) begin
          op_nxt  = ac_pkg::opcode_t'(in_ch.opcode);
          sym_nxt = sym_map[in_ch.data_byte];
          case (ac_pkg::opcode_t'(in_ch.opcode))
            ac_pkg::OP_CLEAR: begin
              node_cnt_nxt  = NCW'(1);
              cursor_nxt    = '0;
              total_nxt     = '0;
              root_term_nxt = 1'b0;
            end
            ac_pkg::OP_PAT_BYTE: begin
              n_nxt   = cursor_r;
              ctx_nxt = ac_pkg::CTX_PAT;
            end
            ac_pkg::OP_PAT_END: begin
              if (cursor_r == '0) begin
                root_term_nxt = 1'b1;
              end
              n_nxt      = cursor_r;
              ctx_nxt    = ac_pkg::CTX_ENDP;
              cursor_nxt = '0;
            end
            ac_pkg::OP_BUILD: begin
              n_nxt    = '0;
              sym_nxt  = '0;
              head_nxt = '0;
              tail_nxt = '0;
              ctx_nxt  = ac_pkg::CTX_ROOT;
            end
            ac_pkg::OP_TEXT_BYTE: begin
              n_nxt     = cursor_r;
              steps_nxt = '0;
            end
            ac_pkg::OP_LINE_END: cursor_nxt = '0;
            default: ;
          endcase
        end
      end
      ac_pkg::S_WALK: ctx_nxt = (n_r == '0) ? ac_pkg::CTX_FINAL : ac_pkg::CTX_WALK;
      ac_pkg::S_E_RD: goto_addr_nxt = goto_addr;
      ac_pkg::S_E_META: c_nxt = goto_q;
      ac_pkg::S_E_CHK: begin
        case (ctx_r)
          ac_pkg::CTX_PAT: begin
            if (hit) begin
              cursor_nxt = c_r;
            end else if (full) begin
              done_status = 1'b1;
            end else begin
              node_we      = 1'b1;
              node_waddr   = node_cnt_r[NW-1:0];
              node_wdata   = {n_r, sym_r, {NW{1'b0}}, 1'b0};
              goto_we      = 1'b1;
              cursor_nxt   = node_cnt_r[NW-1:0];
              node_cnt_nxt = node_cnt_r + NCW'(1);
            end
          end
          ac_pkg::CTX_WALK: begin
            if (!hit && steps_r >= NCW'(NODES)) begin
              n_nxt   = '0;
              ctx_nxt = ac_pkg::CTX_FINAL;
            end
          end
          ac_pkg::CTX_ROOT: begin
            if (hit) begin
              node_we    = 1'b1;
              node_waddr = c_r;
              node_wdata = {q_par, q_sym, {NW{1'b0}}, node_q[0]};
              if (tail_r < NCW'(NODES)) begin
                q_we     = 1'b1;
                tail_nxt = tail_r + NCW'(1);
              end
            end
            if (!sym_last) begin
              sym_nxt = sym_r + SW'(1);
            end
          end
          ac_pkg::CTX_CHILD: begin
            if (hit) begin
              child_nxt      = c_r;
              child_par_nxt  = q_par;
              child_term_nxt = node_q[0];
              n_nxt          = ufail_r;
              steps_nxt      = '0;
            end
          end
          default: ;
        endcase

        if (walk_fin) begin
          if (op_r == ac_pkg::OP_TEXT_BYTE) begin
            if (term_e) begin
              done_matched = 1'b1;
              if (total_r != ac_pkg::TOTAL_MAX) begin
                total_nxt = total_r + ac_pkg::CNT_W'(1);
              end
              cursor_nxt = '0;
            end else begin
              cursor_nxt = e;
            end
          end else begin
            node_we    = 1'b1;
            node_waddr = child_r;
            node_wdata = {child_par_r, sym_r, e, child_term_r | term_e};
            q_wdata    = child_r;
            if (tail_r < NCW'(NODES)) begin
              q_we     = 1'b1;
              tail_nxt = tail_r + NCW'(1);
            end
          end
        end
      end
      ac_pkg::S_NODE_Q: begin
        if (ctx_r == ac_pkg::CTX_WALK) begin
          n_nxt     = q_fail;
          steps_nxt = steps_r + NCW'(1);
        end else begin
          node_we    = 1'b1;
          node_wdata = {node_q[NDW-1:1], 1'b1};
        end
      end
      ac_pkg::S_NEXT_SYM: begin
        if (!sym_last) begin
          sym_nxt = sym_r + SW'(1);
          n_nxt   = u_r;
          ctx_nxt = ac_pkg::CTX_CHILD;
        end
      end
      ac_pkg::S_Q_RD: begin
        if (head_r != tail_r) begin
          head_nxt = head_r + NCW'(1);
        end
      end
      ac_pkg::S_Q_WAIT: u_nxt = q_q;
      ac_pkg::S_U_FAIL: begin
        ufail_nxt = q_fail;
        sym_nxt   = '0;
        n_nxt     = u_r;
        ctx_nxt   = ac_pkg::CTX_CHILD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ac_pkg::S_IDLE;
      node_cnt_r  <= NCW'(1);
      cursor_r    <= '0;
      total_r     <= '0;
      root_term_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      node_cnt_r  <= node_cnt_nxt;
      cursor_r    <= cursor_nxt;
      total_r     <= total_nxt;
      root_term_r <= root_term_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx_r        <= ctx_nxt;
    op_r         <= op_nxt;
    sym_r        <= sym_nxt;
    n_r          <= n_nxt;
    c_r          <= c_nxt;
    u_r          <= u_nxt;
    ufail_r      <= ufail_nxt;
    child_r      <= child_nxt;
    child_par_r  <= child_par_nxt;
    child_term_r <= child_term_nxt;
    steps_r      <= steps_nxt;
    goto_addr_r  <= goto_addr_nxt;
    if (done) begin
      out_matched_r <= done_matched;
      out_total_r   <= total_nxt;
      out_status_r  <= done_status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.matched     = out_matched_r;
  assign out_ch.total_count = out_total_r;
  assign out_ch.status      = out_status_r;

  a_node_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    (node_cnt_r != '0) && (node_cnt_r <= NCW'(NODES)))
    else $error("node count out of range");

  a_queue_order : assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("bfs queue head passed tail");

  a_match_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_matched_r && out_status_r))
    else $error("match and trie-full reported together");

  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ac_pkg::S_IDLE) |-> !in_ch.ready)
    else $error("command taken while sequencer busy");

endmodule

`default_nettype wire

@@ rtl/ac_ram.sv @@
// ----------------------------------------------------------------------------
// ac_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // power-up contents are zero
  initial begin
    for (int i = 0; i < D; i++) begin
      mem[i] = '0;
    end
  end

  always @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
